// ===== hw/rtl/lkvc_pkg.sv =====
package lkvc_pkg;

  // Width of the capacity register.
  localparam int CAP_W = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request kinds.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Status that each cell reports to the control logic.
  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

endpackage

// ===== hw/rtl/lkvc_cell.sv =====
module lkvc_cell #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd,
  input  logic                   src_valid,
  input  logic [KEY_WIDTH-1:0]   src_key,
  input  logic [VALUE_WIDTH-1:0] src_value,
  input  logic [KEY_WIDTH-1:0]   probe_key,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output lkvc_pkg::cell_stat_t   stat
);
  import lkvc_pkg::*;

  logic valid;

  // The valid bit is control state; key and value are payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      key   <= src_key;
      value <= src_value;
    end
  end

  assign stat.valid = valid;
  assign stat.match = valid && (key == probe_key);

endmodule

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// A result is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle while results are taken; the input stalls
// only while a finished result waits under out_stall. This rate rests on the
// parallel key compare and the single-step shift of the cell chain.
// Reset (synchronous, active high) empties the store, sets capacity to 16 and
// drops any pending result.
module lru_key_value_cache_top #(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // Capacity register write port.
  input  logic                     cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic [KEY_WIDTH-1:0]     lookup_key,
  input  logic [VALUE_WIDTH-1:0]   write_value,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [VALUE_WIDTH-1:0]   read_value,
  output logic                     evicted,
  output logic [KEY_WIDTH-1:0]     evicted_key
);
  import lkvc_pkg::*;

  // CNT_W holds an entry count from zero to ENTRIES inclusive; IDX_W indexes
  // one cell.
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // The cells are kept in recency order: cell 0 holds the most recent entry
  // and the valid cells always form a prefix whose length is the occupancy.
  // Touching the entry at position b moves it to the front while every cell
  // ahead of it hands its contents one step down the chain. An insert uses
  // b = occupancy, which extends the prefix by one; an eviction uses
  // b = occupancy - 1, so the least recent entry falls off the end of the
  // prefix and its key is reported.

  logic [CAP_W-1:0]       capacity;
  logic [CNT_W-1:0]       occupancy;
  logic [CNT_W-1:0]       occupancy_next;
  logic [CNT_W-1:0]       cap_eff;

  logic [KEY_WIDTH-1:0]   cell_key   [ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_value [ENTRIES];
  cell_stat_t             cell_stat  [ENTRIES];
  logic [ENTRIES-1:0]     match_vec;
  logic [ENTRIES-1:0]     valid_vec;
  logic [ENTRIES-1:0]     occ_mask;
  logic [ENTRIES-1:0]     upd;

  logic                   accept;
  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic                   full;
  logic                   do_update;
  logic                   do_evict;
  logic [CNT_W-1:0]       bound;
  logic [IDX_W-1:0]       evict_idx;
  logic [VALUE_WIDTH-1:0] front_value;

  // The capacity register is written whenever the enable is high and reset is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Zero counts as one, and anything beyond the cell count as the cell count.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // A new item is taken unless a finished result is still being held.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Parallel compare results; at most one cell can match since keys are
  // unique in the store.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int p = ENTRIES - 1; p >= 0; p--) begin
      if (match_vec[p]) begin
        hit_idx = IDX_W'(p);
      end
    end
    for (int p = 0; p < ENTRIES; p++) begin
      if (match_vec[p]) begin
        hit_value = hit_value | cell_value[p];
      end
    end
  end

  assign hit_any   = |match_vec;
  assign full      = (occupancy >= cap_eff);
  assign do_update = accept && (hit_any || (op == OP_PUT));
  assign do_evict  = accept && !hit_any && (op == OP_PUT) && full;
  assign evict_idx = IDX_W'(occupancy - CNT_W'(1));

  // Position that the touched entry comes from.
  always_comb begin
    if (hit_any) begin
      bound = CNT_W'(hit_idx);
    end else if (full) begin
      bound = occupancy - CNT_W'(1);
    end else begin
      bound = occupancy;
    end
  end

  // The front cell takes the new value on a put, the old one on a get hit.
  assign front_value = (op == OP_PUT) ? write_value : hit_value;

  // Only a put of a key that is absent while there is room grows the store.
  always_comb begin
    occupancy_next = occupancy;
    if (accept && (op == OP_PUT) && !hit_any && !full) begin
      occupancy_next = occupancy + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    assign upd[p]       = do_update && (CNT_W'(p) <= bound);
    assign match_vec[p] = cell_stat[p].match;
    assign valid_vec[p] = cell_stat[p].valid;
    assign occ_mask[p]  = (CNT_W'(p) < occupancy);

    if (p == 0) begin : g_head
      lkvc_cell #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .upd       (upd[p]),
        .src_valid (1'b1),
        .src_key   (lookup_key),
        .src_value (front_value),
        .probe_key (lookup_key),
        .key       (cell_key[p]),
        .value     (cell_value[p]),
        .stat      (cell_stat[p])
      );
    end else begin : g_body
      lkvc_cell #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .upd       (upd[p]),
        .src_valid (cell_stat[p-1].valid),
        .src_key   (cell_key[p-1]),
        .src_value (cell_value[p-1]),
        .probe_key (lookup_key),
        .key       (cell_key[p]),
        .value     (cell_value[p]),
        .stat      (cell_stat[p])
      );
    end
  end

  // Output register. It loads on every accepted item and empties when the
  // result is taken without a new one arriving.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit         <= hit_any;
      read_value  <= (hit_any && (op == OP_GET)) ? hit_value : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? cell_key[evict_idx] : '0;
    end
  end

  // The valid cells always form a prefix as long as the occupancy.
  assert property (@(posedge clk) disable iff (rst) valid_vec == occ_mask)
    else $error("valid cells do not match occupancy");

  // A key is never held by two cells.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("key present in more than one cell");

  // An eviction comes only from a miss.
  assert property (@(posedge clk) disable iff (rst) (out_valid && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  // A get never changes the number of stored entries.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_GET)) |=> (occupancy == $past(occupancy)))
    else $error("occupancy changed on a get");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

// Checks the LRU key-value cache against an in-bench model of its entries,
// recency ranks and capacity. Requests are queued by the stimulus process,
// pushed through the request channel by a clocked driver, and every reply is
// compared with the prediction made when its request was accepted.
module tb;
  import lkvc_pkg::*;

  localparam int ENTRIES = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Length of the one long receiver hold-off, and the reply count that starts it.
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT_REPLY = 150;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_reply_t;

  // Every input of the block starts at a known value.
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             op = OP_GET;
  logic [KEY_W-1:0] lookup_key = '0;
  logic [VAL_W-1:0] write_value = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;

  lru_key_value_cache_top #(
    .ENTRIES(ENTRIES),
    .KEY_WIDTH(KEY_W),
    .VALUE_WIDTH(VAL_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .lookup_key(lookup_key),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .read_value(read_value),
    .evicted(evicted),
    .evicted_key(evicted_key)
  );

  always #6 clk = ~clk;

  // Requests waiting to be driven, and replies predicted for accepted requests.
  cache_req_t   pending_requests[$];
  cache_reply_t predicted_replies[$];

  // Idle percentages for each side; the stimulus process changes them between phases.
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 67;
  int          error_count = 0;

  // Shadow copy of the cache contents. Rank 0 is the most recent valid entry.
  logic             shadow_valid[ENTRIES];
  logic [KEY_W-1:0] shadow_key[ENTRIES];
  logic [VAL_W-1:0] shadow_value[ENTRIES];
  int unsigned      shadow_rank[ENTRIES];
  int unsigned      shadow_occupancy;
  logic [CAP_W-1:0] shadow_capacity;

  wire request_taken = in_valid && !in_stall;
  wire reply_taken = out_valid && !out_stall;

  // A capacity of zero behaves as one, and anything beyond the entry count as
  // the entry count.
  function automatic int unsigned effective_capacity(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > ENTRIES) return ENTRIES;
    return cap;
  endfunction

  // Moves an entry to the front: every other valid entry that was more recent
  // than the given rank ages by one.
  task automatic mark_recent(input int slot, input int unsigned limit);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (i != slot && shadow_valid[i] && shadow_rank[i] < limit) shadow_rank[i]++;
    end
    shadow_rank[slot] = 0;
  endtask

  // Applies one accepted request to the shadow cache and returns its reply.
  task automatic predict_lookup(input logic req_op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, output cache_reply_t reply);
    int unsigned cap;
    int          slot;
    int          i;
    reply = '0;
    cap = effective_capacity(shadow_capacity);
    slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      reply.hit = 1'b1;
      if (req_op == OP_GET) reply.read_value = shadow_value[slot];
      else shadow_value[slot] = value;
      mark_recent(slot, shadow_rank[slot]);
    end else if (req_op == OP_PUT) begin
      if (shadow_occupancy >= cap) begin
        // The store is full for this capacity: the oldest entry gives up its slot.
        for (i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && shadow_valid[i] && shadow_rank[i] == shadow_occupancy - 1) slot = i;
        end
        if (slot >= 0) begin
          reply.evicted = 1'b1;
          reply.evicted_key = shadow_key[slot];
          shadow_key[slot] = key;
          shadow_value[slot] = value;
          mark_recent(slot, shadow_occupancy - 1);
        end
      end else begin
        for (i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          shadow_valid[slot] = 1'b1;
          shadow_key[slot] = key;
          shadow_value[slot] = value;
          mark_recent(slot, shadow_occupancy);
          shadow_occupancy++;
        end
      end
    end
  endtask

  // Driver. A new item is offered only once the previous one was taken, so a
  // stalled item never changes. The decision to idle never looks at the stall.
  always @(posedge clk) begin : request_driver
    cache_reply_t prediction;
    cache_req_t   next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (request_taken) begin
        predict_lookup(op, lookup_key, write_value, prediction);
        predicted_replies.push_back(prediction);
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          op <= next_req.op;
          lookup_key <= next_req.key;
          write_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each reply taken is checked against the oldest prediction. Once,
  // after a fixed number of replies, the receiver holds off for a long stretch
  // so that the result register fills and the block must stall its input.
  always @(posedge clk) begin : reply_monitor
    cache_reply_t want;
    int           replies_seen;
    int           hold_left;
    bit           hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      replies_seen = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (reply_taken) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          $display("%0t: reply with no request outstanding (hit %0b, evicted %0b)",
                   $time, hit, evicted);
          error_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, hit);
            error_count++;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h, got %h", $time, want.read_value,
                     read_value);
            error_count++;
          end
          if (evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b, got %0b", $time, want.evicted, evicted);
            error_count++;
          end
          if (evicted_key !== want.evicted_key) begin
            $display("%0t: evicted_key expected %h, got %h", $time, want.evicted_key,
                     evicted_key);
            error_count++;
          end
        end
      end
      if (!hold_done && replies_seen >= HOLD_AT_REPLY) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: a long run of cycles with no item moving on either side means
  // the block has hung.
  always @(posedge clk) begin : hang_watch
    int quiet_cycles;
    if (rst) begin
      quiet_cycles = 0;
    end else if (request_taken || reply_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic req_op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    cache_req_t req;
    req.op = req_op;
    req.key = key;
    req.value = value;
    pending_requests.push_back(req);
  endtask

  // Waits until every queued request was taken and every reply has come back,
  // then lets the registered result path settle. Each check runs a little after the
  // clock edge, once the driver's and the monitor's updates of that edge have
  // landed, so an item popped from the queue is always seen as in flight.
  task automatic wait_for_idle();
    @(posedge clk);
    #1;
    while (pending_requests.size() != 0 || in_valid || predicted_replies.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (2) @(posedge clk);
  endtask

  // Only called while the block is idle, so the shadow copy can follow at once.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = cap;
  endtask

  // Random phase: most requests use a small set of keys, a little larger than
  // the capacity, so gets hit, puts update and new keys evict. The rest carry
  // fully random keys, which almost always miss.
  task automatic queue_random_phase(input int count);
    logic [KEY_W-1:0] key_set[$];
    int               set_size;
    int               k;
    cache_req_t       req;
    set_size = effective_capacity(shadow_capacity) + $urandom_range(3);
    for (k = 0; k < set_size; k++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: key_set.push_back('0);
          1: key_set.push_back('1);
          2: key_set.push_back(32'h8000_0000);
          default: key_set.push_back(32'h7FFF_FFFF);
        endcase
      end else begin
        key_set.push_back($urandom);
      end
    end
    for (k = 0; k < count; k++) begin
      req.op = $urandom_range(1) ? OP_PUT : OP_GET;
      req.value = $urandom;
      if ($urandom_range(99) < 85) req.key = key_set[$urandom_range(set_size - 1)];
      else req.key = $urandom;
      pending_requests.push_back(req);
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] cap_plan[9];
    int               regime;
    int               p;
    int               i;

    // The shadow cache starts empty, as the block does after reset.
    for (i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_occupancy = 0;
    shadow_capacity = CAP_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity: a get on the empty store, puts of
    // the extreme keys and values, hits, an update of a present key, a miss,
    // and a get whose write value must be ignored.
    queue_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    queue_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(OP_GET, 32'h0000_0001, 32'h0000_0000);
    queue_req(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    wait_for_idle();

    // Capacity lowered below the four entries in use: each new key evicts
    // exactly one old entry and the occupancy stays where it is.
    write_capacity(5'd2);
    queue_req(OP_PUT, 32'h0000_0002, 32'h0000_0022);
    queue_req(OP_PUT, 32'h0000_0003, 32'h0000_0033);
    queue_req(OP_GET, 32'h0000_0002, 32'h0000_0000);
    queue_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
    wait_for_idle();

    // A capacity of zero behaves as one.
    write_capacity(5'd0);
    queue_req(OP_PUT, 32'h0000_0004, 32'h0000_0044);
    queue_req(OP_PUT, 32'h0000_0005, 32'h0000_0055);
    queue_req(OP_GET, 32'h0000_0004, 32'h0000_0000);
    queue_req(OP_GET, 32'h0000_0005, 32'h0000_0000);
    wait_for_idle();

    // A capacity beyond the entry count behaves as the full store.
    write_capacity(5'd31);
    queue_req(OP_PUT, 32'h0000_0006, 32'h0000_0066);
    queue_req(OP_PUT, 32'h0000_0007, 32'h0000_0077);
    queue_req(OP_GET, 32'h0000_0006, 32'h0000_0000);
    queue_req(OP_GET, 32'h0000_0003, 32'h0000_0000);

    // Random phases. The first three run with the sender mostly busy and the
    // receiver often stalling, the next three the other way round, the last
    // three with neither side idling. Capacities include both extremes and
    // the out-of-range values.
    cap_plan[0] = 5'd16; cap_plan[1] = 5'd1;  cap_plan[2] = 5'd7;
    cap_plan[3] = 5'd31; cap_plan[4] = 5'd4;  cap_plan[5] = 5'd0;
    cap_plan[6] = 5'd12; cap_plan[7] = 5'd17; cap_plan[8] = 5'd2;
    for (regime = 0; regime < 3; regime++) begin
      for (p = 0; p < 3; p++) begin
        wait_for_idle();
        if (p == 0) begin
          case (regime)
            0: begin send_idle_pct = 21; recv_idle_pct = 67; end
            1: begin send_idle_pct = 67; recv_idle_pct = 21; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
          endcase
        end
        write_capacity(cap_plan[regime * 3 + p]);
        queue_random_phase(100);
      end
    end

    wait_for_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
